### sv/hspe_pkg.sv
// ----------------------------------------------------------------------------
// hspe_pkg
// Shared types and constants for the height sample pixel encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hspe_pkg;

  // Field widths
  localparam int SAMPLE_W = 48;
  localparam int BYTE_W   = 8;
  localparam int COL_W    = 12;
  localparam int ROW_W_W  = 13;
  localparam int CFG_DW   = 13;

  // Fixed point format of the incoming sample
  localparam int IN_FRAC_BITS = 24;

  // Default for the row width limit
  localparam int MAX_ROW_WIDTH_DEF = 4096;

  // Packed value is at most this many bits
  localparam int PIX_BITS = 24;

  // Register reset values
  localparam logic [4:0]         INT_BITS_RST    = 5'd8;
  localparam logic [4:0]         FRAC_BITS_RST   = 5'd7;
  localparam logic [7:0]         NOISE_RST       = 8'h00;
  localparam logic [ROW_W_W-1:0] ROW_WIDTH_RST   = ROW_W_W'(1440);

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_INT_BITS     = 3'd0,
    CFG_FRAC_BITS    = 3'd1,
    CFG_FLOOR_RAISE  = 3'd2,
    CFG_OVF_MODE     = 3'd3,
    CFG_CHAN_SHIFT   = 3'd4,
    CFG_INT_SHIFT_EN = 3'd5,
    CFG_CHAN_FLOW_EN = 3'd6,
    CFG_ROW_WIDTH    = 3'd7
  } cfg_idx_e;

  // Overflow handling; the unused code behaves as snap wrap
  typedef enum logic [1:0] {
    OVF_SNAP     = 2'd0,
    OVF_BOUNCE   = 2'd1,
    OVF_SATURATE = 2'd2,
    OVF_SNAP_ALT = 2'd3
  } ovf_mode_e;

  // Channel shift; the unused code means no shift
  typedef enum logic [1:0] {
    CSH_NONE     = 2'd0,
    CSH_MSB_RED  = 2'd1,
    CSH_BYTE     = 2'd2,
    CSH_NONE_ALT = 2'd3
  } chan_shift_e;

  // Encoder settings as seen by the pixel packer
  typedef struct packed {
    logic [4:0]  int_bits;
    logic [4:0]  frac_bits;
    logic [7:0]  floor_raise;
    ovf_mode_e   ovf_mode;
    chan_shift_e chan_shift;
    logic        int_shift_en;
    logic        chan_flow_en;
  } pack_cfg_t;

endpackage

`default_nettype wire

### sv/hspe_if.sv
// ----------------------------------------------------------------------------
// hspe_if
// Valid/ready channels for samples in and pixels out.
// ----------------------------------------------------------------------------
`default_nettype none

interface hspe_sample_if
  import hspe_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic                       sample_is_nan;

  modport source (output valid, sample_value, sample_is_nan, input ready);
  modport sink   (input valid, sample_value, sample_is_nan, output ready);
endinterface

interface hspe_pixel_if
  import hspe_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] red_byte;
  logic [BYTE_W-1:0] green_byte;
  logic [BYTE_W-1:0] blue_byte;
  logic [COL_W-1:0]  column_index;
  logic              row_complete;

  modport source (output valid, red_byte, green_byte, blue_byte, column_index,
                  row_complete, input ready);
  modport sink   (input valid, red_byte, green_byte, blue_byte, column_index,
                  row_complete, output ready);
endinterface

`default_nettype wire

### sv/hspe_pack.sv
// ----------------------------------------------------------------------------
// hspe_pack
// Scales one sample, applies overflow handling and packs it into RGB bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module hspe_pack
  import hspe_pkg::*;
(
  input  var pack_cfg_t                  cfg_i,
  input  var logic signed [SAMPLE_W-1:0] sample_value_i,
  input  var logic                       sample_is_nan_i,
  output var logic [BYTE_W-1:0]          red_o,
  output var logic [BYTE_W-1:0]          green_o,
  output var logic [BYTE_W-1:0]          blue_o
);

  logic [4:0]           ib;
  logic [4:0]           fb;
  logic [4:0]           n;
  logic                 neg;
  logic [SAMPLE_W-1:0]  mag;
  logic [5:0]           fb_x;
  logic [63:0]          mag_sc;
  logic [25:0]          mag_c;
  logic signed [27:0]   v;
  logic signed [27:0]   hi;
  logic signed [27:0]   lo;
  logic [24:0]          u25;
  logic [23:0]          u24;
  logic [4:0]           shift;
  logic [23:0]          px;
  logic [BYTE_W-1:0]    red;
  logic [BYTE_W-1:0]    green;
  logic [BYTE_W-1:0]    blue;
  logic [5:0]           t;

  // Effective field widths
  always_comb begin
    ib = cfg_i.int_bits;
    if (ib < 5'd1) ib = 5'd1;
    if (ib > 5'd24) ib = 5'd24;
    fb = cfg_i.frac_bits;
    if (fb > 5'd24 - ib) fb = 5'd24 - ib;
    n = ib + fb;
  end

  // Magnitude, scaled to frac_bits with truncation toward zero
  always_comb begin
    neg  = sample_value_i[SAMPLE_W-1];
    mag  = neg ? (~sample_value_i + SAMPLE_W'(1)) : sample_value_i;
    fb_x = 6'(fb);
    if (fb_x >= 6'(IN_FRAC_BITS)) begin
      mag_sc = 64'(mag) << (fb_x - 6'(IN_FRAC_BITS));
    end else begin
      mag_sc = 64'(mag) >> (6'(IN_FRAC_BITS) - fb_x);
    end
  end

  // Overflow handling, bias and mask to n bits
  always_comb begin
    // large magnitudes clip the same way as their true value would
    mag_c = (|mag_sc[63:26]) ? '1 : mag_sc[25:0];
    v     = neg ? -$signed({2'b00, mag_c}) : $signed({2'b00, mag_c});
    v     = v + $signed(28'(cfg_i.floor_raise >> 1));
    hi    = $signed((28'(1) << (n - 5'd1)) - 28'(1));
    lo    = -hi + $signed(28'(cfg_i.floor_raise));
    if (v > hi) v = hi;
    if (v < lo) v = lo;

    if (cfg_i.ovf_mode == OVF_SATURATE) begin
      u25 = v[24:0];
    end else begin
      u25 = neg ? (~mag_sc[24:0] + 25'd1) : mag_sc[24:0];
    end
    u25 = u25 + (25'(1) << (n - 5'd1));
    if (cfg_i.ovf_mode == OVF_BOUNCE && u25[n]) u25 = ~u25;
    u24 = u25[23:0] & ((24'(1) << n) - 24'(1));
    if (sample_is_nan_i) u24 = '0;
  end

  // Channel shift and byte split
  always_comb begin
    if (n <= 5'd8) begin
      shift = 5'd0;
    end else if (cfg_i.chan_shift == CSH_MSB_RED) begin
      shift = 5'd24 - n;
    end else if (cfg_i.chan_shift == CSH_BYTE && n <= 5'd16) begin
      shift = 5'd8;
    end else begin
      shift = 5'd0;
    end
    px = u24 << shift;
  end

  // Byte bounce inversion, then left-align the partial top channel
  always_comb begin
    blue  = px[7:0];
    green = px[15:8];
    red   = px[23:16];
    if (cfg_i.chan_flow_en) begin
      if (shift < 5'd8 && px[8]) blue = ~px[7:0];
      if (shift < 5'd16 && px[16]) green = ~px[15:8];
    end
    t = 6'(n) + 6'(shift);
    if (cfg_i.int_shift_en) begin
      if (t <= 6'd8) begin
        blue = blue << (6'd8 - t);
      end else if (t <= 6'd16) begin
        green = green << (6'd16 - t);
      end else if (t <= 6'd24) begin
        red = red << (6'd24 - t);
      end
    end
    red_o   = red;
    green_o = green;
    blue_o  = blue;
  end

endmodule

`default_nettype wire

### sv/height_sample_pixel_encoder.sv
// ----------------------------------------------------------------------------
// height_sample_pixel_encoder
// Encodes height samples as RGB pixels with a rotated column index.
// ----------------------------------------------------------------------------
//  Channel    Dir  Handshake       Payload
//  sample_i   in   valid/ready     sample_value (48, signed), sample_is_nan
//  pixel_o    out  valid/ready     red/green/blue_byte, column_index, row_complete
//  cfg_*_i    in   write enable    cfg_idx_i (register), cfg_data_i (13 bits)
//
//  One pixel per sample, one sample per cycle sustained while pixel_o is ready.
//  A transaction is held in the input register, packed by combinational logic
//  and caught in the result register, which drives pixel_o.valid.
//  The column counter advances when a sample is accepted.
//  A stalled pixel_o leaves the input register free for one more transaction.
//  Reset restores the register defaults and puts the column at half the row.
// ----------------------------------------------------------------------------
`default_nettype none

module height_sample_pixel_encoder
  import hspe_pkg::*;
#(
  parameter int MAX_ROW_WIDTH = MAX_ROW_WIDTH_DEF
) (
  input  var logic               clk_i,
  input  var logic               rst_ni,
  hspe_sample_if.sink            sample_i,
  hspe_pixel_if.source           pixel_o,
  input  var logic               cfg_we_i,
  input  var logic [2:0]         cfg_idx_i,
  input  var logic [CFG_DW-1:0]  cfg_data_i
);

  // Column counter widths
  localparam int PW    = (MAX_ROW_WIDTH > 2) ? $clog2(MAX_ROW_WIDTH) : 1;
  localparam int MW    = $clog2(MAX_ROW_WIDTH + 1);
  localparam int RW_W  = (MW > ROW_W_W) ? MW : ROW_W_W;
  localparam int CW    = (RW_W > PW + 1) ? RW_W : PW + 1;
  localparam int XW    = (CW > COL_W) ? CW : COL_W;
  localparam int RST_W = (ROW_WIDTH_RST > MAX_ROW_WIDTH) ? MAX_ROW_WIDTH
                                                         : int'(ROW_WIDTH_RST);
  localparam logic [PW-1:0] POS_RST = PW'(RST_W / 2);

  // Configuration registers
  logic [4:0]         int_bits_q;
  logic [4:0]         frac_bits_q;
  logic [7:0]         noise_q;
  ovf_mode_e          ovf_mode_q;
  chan_shift_e        chan_shift_q;
  logic               int_shift_en_q;
  logic               chan_flow_en_q;
  logic [ROW_W_W-1:0] row_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_bits_q     <= INT_BITS_RST;
      frac_bits_q    <= FRAC_BITS_RST;
      noise_q        <= NOISE_RST;
      ovf_mode_q     <= OVF_SATURATE;
      chan_shift_q   <= CSH_MSB_RED;
      int_shift_en_q <= 1'b1;
      chan_flow_en_q <= 1'b1;
      row_width_q    <= ROW_WIDTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_INT_BITS:     int_bits_q     <= cfg_data_i[4:0];
        CFG_FRAC_BITS:    frac_bits_q    <= cfg_data_i[4:0];
        CFG_FLOOR_RAISE:  noise_q        <= cfg_data_i[7:0];
        CFG_OVF_MODE:     ovf_mode_q     <= ovf_mode_e'(cfg_data_i[1:0]);
        CFG_CHAN_SHIFT:   chan_shift_q   <= chan_shift_e'(cfg_data_i[1:0]);
        CFG_INT_SHIFT_EN: int_shift_en_q <= cfg_data_i[0];
        CFG_CHAN_FLOW_EN: chan_flow_en_q <= cfg_data_i[0];
        CFG_ROW_WIDTH:    row_width_q    <= cfg_data_i[ROW_W_W-1:0];
        default:          ;
      endcase
    end
  end

  pack_cfg_t pack_cfg;

  always_comb begin
    pack_cfg.int_bits     = int_bits_q;
    pack_cfg.frac_bits    = frac_bits_q;
    pack_cfg.floor_raise  = noise_q;
    pack_cfg.ovf_mode     = ovf_mode_q;
    pack_cfg.chan_shift   = chan_shift_q;
    pack_cfg.int_shift_en = int_shift_en_q;
    pack_cfg.chan_flow_en = chan_flow_en_q;
  end

  // Handshake: the input register moves on whenever the result register frees
  logic s1_valid_q;
  logic s2_free;
  logic in_ready;
  logic in_fire;

  assign s2_free        = !pixel_o.valid || pixel_o.ready;
  assign in_ready       = !s1_valid_q || s2_free;
  assign in_fire        = sample_i.valid && in_ready;
  assign sample_i.ready = in_ready;

  // Column counter, with the row width clamped to 2 .. MAX_ROW_WIDTH
  logic [PW-1:0]   pos_q;
  logic [RW_W-1:0] eff_w;
  logic [CW-1:0]   next_pos;
  logic [XW-1:0]   pos_x;
  logic            row_done;

  always_comb begin
    eff_w = RW_W'(row_width_q);
    if (eff_w < RW_W'(2)) eff_w = RW_W'(2);
    if (eff_w > RW_W'(MAX_ROW_WIDTH)) eff_w = RW_W'(MAX_ROW_WIDTH);
    next_pos = CW'(pos_q) + CW'(1);
    if (next_pos >= CW'(eff_w)) next_pos = '0;
    row_done = (next_pos == CW'(eff_w >> 1));
    pos_x    = XW'(pos_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= POS_RST;
    end else if (in_fire) begin
      pos_q <= next_pos[PW-1:0];
    end
  end

  // Input register
  logic signed [SAMPLE_W-1:0] s1_value_q;
  logic                       s1_nan_q;
  logic [COL_W-1:0]           s1_col_q;
  logic                       s1_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_value_q <= sample_i.sample_value;
      s1_nan_q   <= sample_i.sample_is_nan;
      s1_col_q   <= pos_x[COL_W-1:0];
      s1_done_q  <= row_done;
    end
  end

  // Pixel packing
  logic [BYTE_W-1:0] red_d;
  logic [BYTE_W-1:0] green_d;
  logic [BYTE_W-1:0] blue_d;

  hspe_pack u_pack (
    .cfg_i           (pack_cfg),
    .sample_value_i  (s1_value_q),
    .sample_is_nan_i (s1_nan_q),
    .red_o           (red_d),
    .green_o         (green_d),
    .blue_o          (blue_d)
  );

  // Result register
  logic              out_valid_q;
  logic [BYTE_W-1:0] red_q;
  logic [BYTE_W-1:0] green_q;
  logic [BYTE_W-1:0] blue_q;
  logic [COL_W-1:0]  col_q;
  logic              done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_free && s1_valid_q) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      col_q   <= s1_col_q;
      done_q  <= s1_done_q;
    end
  end

  assign pixel_o.valid        = out_valid_q;
  assign pixel_o.red_byte     = red_q;
  assign pixel_o.green_byte   = green_q;
  assign pixel_o.blue_byte    = blue_q;
  assign pixel_o.column_index = col_q;
  assign pixel_o.row_complete = done_q;

endmodule

`default_nettype wire

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for height_sample_pixel_encoder. Samples are queued in
// phases, each under its own register setting, and driven over the sample
// channel with random gaps. Every accepted sample is run through a local
// model of the packer and column counter. The resulting pixel is queued
// and compared field by field as the pixel channel delivers it.
// ----------------------------------------------------------------------------

module tb;
  import hspe_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int ERR_PRINT_MAX = 200;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                nan;
  } sample_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [COL_W-1:0]  col;
    logic              row_done;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic              cfg_we;
  logic [2:0]        cfg_idx;
  logic [CFG_DW-1:0] cfg_data;

  hspe_sample_if smp ();
  hspe_pixel_if  pix ();

  height_sample_pixel_encoder u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_i   (smp),
    .pixel_o    (pix),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Local copy of the encoder registers and the column counter
  logic [4:0]         int_bits_q;
  logic [4:0]         frac_bits_q;
  logic [7:0]         noise_q;
  ovf_mode_e          ovf_q;
  chan_shift_e        csh_q;
  logic               int_shift_q;
  logic               chan_flow_q;
  logic [ROW_W_W-1:0] row_width_q;
  int unsigned        col_pos;

  sample_t sample_q[$];
  pixel_t  pixel_expect_q[$];

  int unsigned idle_odds;      // 0: no idling, else an idle starts with odds 1 in idle_odds
  int unsigned src_gap;
  int unsigned snk_gap;
  int unsigned hold_left;
  int unsigned pixels_seen;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  function automatic int unsigned eff_int_bits();
    int unsigned ib;
    ib = int_bits_q;
    if (ib < 1) ib = 1;
    if (ib > 24) ib = 24;
    return ib;
  endfunction

  function automatic int unsigned eff_frac_bits();
    int unsigned fb;
    fb = frac_bits_q;
    if (fb > 24 - eff_int_bits()) fb = 24 - eff_int_bits();
    return fb;
  endfunction

  // Pixel for one sample; also steps the column counter
  function automatic pixel_t encode_height(logic [SAMPLE_W-1:0] raw, logic nan);
    logic [63:0]       mag;
    logic [63:0]       u;
    longint            v;
    longint            hi;
    longint            lo;
    int unsigned       n;
    int unsigned       fb;
    int unsigned       sh;
    int unsigned       t;
    int unsigned       w;
    int unsigned       nxt;
    logic              neg;
    logic [BYTE_W-1:0] r;
    logic [BYTE_W-1:0] g;
    logic [BYTE_W-1:0] b;
    pixel_t            px;
    fb = eff_frac_bits();
    n = eff_int_bits() + fb;
    neg = raw[SAMPLE_W-1];
    mag = neg ? ((64'd1 << SAMPLE_W) - {16'd0, raw}) : {16'd0, raw};
    // truncation toward zero works on the magnitude
    mag = mag >> (IN_FRAC_BITS - fb);

    if (ovf_q == OVF_SATURATE) begin
      v = neg ? -longint'(mag) : longint'(mag);
      hi = longint'((64'd1 << (n - 1)) - 64'd1);
      lo = -hi + longint'({56'd0, noise_q});
      v = v + longint'({57'd0, noise_q[7:1]});
      // upper bound first, so a large margin lets the floor win
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      u = 64'(v);
    end else begin
      u = neg ? (64'd0 - mag) : mag;
    end

    // bias to unsigned, bounce folds on the carry out of n bits
    u = u + (64'd1 << (n - 1));
    if (ovf_q == OVF_BOUNCE && u[n]) u = ~u;
    u = u & ((64'd1 << n) - 64'd1);
    if (nan) u = '0;

    if (n <= 8) sh = 0;
    else if (csh_q == CSH_MSB_RED) sh = 24 - n;
    else if (csh_q == CSH_BYTE && n <= 16) sh = 8;
    else sh = 0;
    u = u << sh;
    b = u[7:0];
    g = u[15:8];
    r = u[23:16];

    // blue looks at green before green itself is flipped
    if (chan_flow_q) begin
      if (sh < 8 && g[0]) b = ~b;
      if (sh < 16 && r[0]) g = ~g;
    end

    if (int_shift_q) begin
      t = n + sh;
      if (t <= 8) b = b << (8 - t);
      else if (t <= 16) g = g << (16 - t);
      else if (t <= 24) r = r << (24 - t);
    end

    w = row_width_q;
    if (w < 2) w = 2;
    if (w > MAX_ROW_WIDTH_DEF) w = MAX_ROW_WIDTH_DEF;
    px.red = r;
    px.green = g;
    px.blue = b;
    px.col = col_pos[COL_W-1:0];
    nxt = col_pos + 1;
    if (nxt >= w) nxt = 0;
    col_pos = nxt;
    px.row_done = (nxt == w / 2);
    return px;
  endfunction

  // Random sample: full range, small, or around the overflow point of the current format
  function automatic sample_t pick_sample();
    sample_t     s;
    logic [63:0] r;
    logic [63:0] step;
    int unsigned k;
    r = {$urandom(), $urandom()};
    k = eff_int_bits() + IN_FRAC_BITS;
    step = 64'd1 << (IN_FRAC_BITS - eff_frac_bits());
    s.nan = ($urandom_range(0, 15) == 0);
    case ($urandom_range(0, 3))
      0: s.value = r[SAMPLE_W-1:0];
      1: r = r & ((64'd1 << (k + 1)) - 64'd1);
      2: r = (64'd1 << (k - 1)) - 2 * step + (r % (4 * step + 1));
      default: r = r & 64'hff_ffff;
    endcase
    if ($urandom_range(0, 1) == 1) r = 64'd0 - r;
    s.value = r[SAMPLE_W-1:0];
    return s;
  endfunction

  task automatic note_pixel_error(string field, int unsigned want_v, int unsigned got_v);
    mismatches++;
    if (mismatches <= ERR_PRINT_MAX)
      $display("pixel %0d %s: expected 0x%0h, got 0x%0h", pixels_seen, field, want_v, got_v);
  endtask

  task automatic push_sample(logic [SAMPLE_W-1:0] value, logic nan);
    sample_t s;
    s.value = value;
    s.nan = nan;
    sample_q.push_back(s);
  endtask

  // Leaves the write enable high; the caller lowers it after the batch
  task automatic write_reg(cfg_idx_e idx, int unsigned val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= CFG_DW'(val);
    case (idx)
      CFG_INT_BITS:     int_bits_q = val[4:0];
      CFG_FRAC_BITS:    frac_bits_q = val[4:0];
      CFG_FLOOR_RAISE:  noise_q = val[7:0];
      CFG_OVF_MODE:     ovf_q = ovf_mode_e'(val[1:0]);
      CFG_CHAN_SHIFT:   csh_q = chan_shift_e'(val[1:0]);
      CFG_INT_SHIFT_EN: int_shift_q = val[0];
      CFG_CHAN_FLOW_EN: chan_flow_q = val[0];
      default:          row_width_q = val[ROW_W_W-1:0];
    endcase
  endtask

  task automatic apply_settings(int unsigned ib, int unsigned fb, int unsigned nm,
                                int unsigned ovf, int unsigned csh, int unsigned ise,
                                int unsigned cfe, int unsigned rw);
    write_reg(CFG_INT_BITS, ib);
    write_reg(CFG_FRAC_BITS, fb);
    write_reg(CFG_FLOOR_RAISE, nm);
    write_reg(CFG_OVF_MODE, ovf);
    write_reg(CFG_CHAN_SHIFT, csh);
    write_reg(CFG_INT_SHIFT_EN, ise);
    write_reg(CFG_CHAN_FLOW_EN, cfe);
    write_reg(CFG_ROW_WIDTH, rw);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Wait for every queued sample to go in and every pixel to come out
  task automatic drain_pipe();
    while (sample_q.size() != 0 || pixel_expect_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Sample driver: holds an offered transaction until it is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp.valid <= 1'b0;
      smp.sample_value <= '0;
      smp.sample_is_nan <= 1'b0;
      src_gap = 0;
    end else begin
      if (smp.valid && smp.ready) begin
        pixel_expect_q.push_back(encode_height(smp.sample_value, smp.sample_is_nan));
        void'(sample_q.pop_front());
      end
      if (!smp.valid || smp.ready) begin
        if (src_gap > 0) begin
          smp.valid <= 1'b0;
          src_gap--;
        end else if (sample_q.size() == 0) begin
          smp.valid <= 1'b0;
        end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
          smp.valid <= 1'b0;
          src_gap = $urandom_range(0, 2);
        end else begin
          smp.valid <= 1'b1;
          smp.sample_value <= sample_q[0].value;
          smp.sample_is_nan <= sample_q[0].nan;
        end
      end
    end
  end

  // Pixel monitor and ready control
  always @(posedge clk_i or negedge rst_ni) begin : check_pixels
    pixel_t want;
    if (!rst_ni) begin
      pix.ready <= 1'b0;
      hold_left = 0;
      snk_gap = 0;
    end else begin
      if (pix.valid && pix.ready) begin
        pixels_seen++;
        // long back-pressure while samples keep coming
        if (pixels_seen == 100 || pixels_seen == 400) hold_left = 40;
        if (pixel_expect_q.size() == 0) begin
          note_pixel_error("with nothing pending", 0, 0);
        end else begin
          want = pixel_expect_q.pop_front();
          if (pix.red_byte !== want.red)
            note_pixel_error("red_byte", want.red, pix.red_byte);
          if (pix.green_byte !== want.green)
            note_pixel_error("green_byte", want.green, pix.green_byte);
          if (pix.blue_byte !== want.blue)
            note_pixel_error("blue_byte", want.blue, pix.blue_byte);
          if (pix.column_index !== want.col)
            note_pixel_error("column_index", want.col, pix.column_index);
          if (pix.row_complete !== want.row_done)
            note_pixel_error("row_complete", want.row_done, pix.row_complete);
        end
      end
      if (hold_left > 0) begin
        pix.ready <= 1'b0;
        hold_left--;
      end else if (snk_gap > 0) begin
        pix.ready <= 1'b0;
        snk_gap--;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        pix.ready <= 1'b0;
        snk_gap = $urandom_range(0, 2);
      end else begin
        pix.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if ((smp.valid && smp.ready) || (pix.valid && pix.ready)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int unsigned ib;
    int unsigned ibc;
    int unsigned fb;
    int unsigned rw;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_INT_BITS;
    cfg_data = '0;
    smp.valid = 1'b0;
    smp.sample_value = '0;
    smp.sample_is_nan = 1'b0;
    pix.ready = 1'b0;
    quiet_cycles = 0;
    pixels_seen = 0;
    mismatches = 0;
    idle_odds = 4;

    int_bits_q = INT_BITS_RST;
    frac_bits_q = FRAC_BITS_RST;
    noise_q = NOISE_RST;
    ovf_q = OVF_SATURATE;
    csh_q = CSH_MSB_RED;
    int_shift_q = 1'b1;
    chan_flow_q = 1'b1;
    row_width_q = ROW_WIDTH_RST;
    col_pos = ROW_WIDTH_RST / 2;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset format Q8.7, saturating, around the clamp points
    push_sample(48'h0000_0000_0000, 1'b0);
    push_sample(48'h0000_0000_0001, 1'b0);
    push_sample(48'hffff_ffff_ffff, 1'b0);
    push_sample(48'h7fff_ffff_ffff, 1'b0);
    push_sample(48'h8000_0000_0000, 1'b0);
    push_sample(48'h0000_7fff_ffff, 1'b0);
    push_sample(48'h0000_8000_0000, 1'b0);
    push_sample(48'hffff_8000_0000, 1'b0);
    push_sample(48'hffff_7fff_ffff, 1'b0);
    push_sample(48'h0000_0100_0000, 1'b0);
    push_sample(48'hffff_ff00_0000, 1'b0);
    push_sample(48'h0000_0000_1234, 1'b1);
    push_sample(48'h7fff_ffff_ffff, 1'b1);
    drain_pipe();

    // Directed: extreme settings, clamped fields and spare codes
    apply_settings(24, 0, 255, OVF_SATURATE, CSH_NONE, 0, 0, 2);
    push_sample(48'h7fff_ffff_ffff, 1'b0);
    push_sample(48'h8000_0000_0000, 1'b0);
    drain_pipe();
    apply_settings(1, 0, 0, OVF_BOUNCE, CSH_BYTE, 1, 1, 4096);
    push_sample(48'h7fff_ffff_ffff, 1'b0);
    push_sample(48'h8000_0000_0000, 1'b0);
    drain_pipe();
    apply_settings(0, 31, 255, OVF_SNAP_ALT, CSH_NONE_ALT, 1, 1, 8191);
    push_sample(48'h7fff_ffff_ffff, 1'b0);
    push_sample(48'h8000_0000_0000, 1'b0);
    drain_pipe();
    // narrow row while the column sits past it
    apply_settings(31, 31, 200, OVF_SNAP, CSH_MSB_RED, 1, 0, 1);
    push_sample(48'h7fff_ffff_ffff, 1'b0);
    push_sample(48'h8000_0000_0000, 1'b0);
    drain_pipe();
    // margin above the range: the raised floor wins
    apply_settings(4, 4, 255, OVF_SATURATE, CSH_BYTE, 0, 1, 0);
    push_sample(48'h7fff_ffff_ffff, 1'b0);
    push_sample(48'h8000_0000_0000, 1'b0);
    drain_pipe();

    // Random phases, each under a fresh setting; the last one runs flat out
    for (int p = 0; p < 8; p++) begin
      ib = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 24);
      ibc = (ib < 1) ? 1 : ((ib > 24) ? 24 : ib);
      fb = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 24 - ibc);
      rw = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 8191) : $urandom_range(2, 40);
      apply_settings(ib, fb, $urandom_range(0, 255), $urandom_range(0, 3),
                     $urandom_range(0, 3), $urandom_range(0, 1), $urandom_range(0, 1), rw);
      if (p == 7) idle_odds = 0;
      else idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 8);
      for (int i = 0; i < 66; i++) sample_q.push_back(pick_sample());
      drain_pipe();
    end

    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
